### rtl/core/tmc_pkg.sv
// Shared types and fixed widths for the tile mean colour block.
package tmc_pkg;

    localparam int CH    = 4;   // red, green, blue, alpha
    localparam int PIX_W = 8;
    localparam int SUM_W = 19;  // per-channel tile sum, wraps at this width
    localparam int X_W   = 20;  // sum plus rounding half-area
    localparam int IDX_W = 4;   // reported tile row / column width

    typedef logic [CH-1:0][PIX_W-1:0] t_chan;
    typedef logic [CH-1:0][SUM_W-1:0] t_sums;
    typedef logic [CH-1:0][X_W-1:0]   t_xs;

    // Per-pixel position flags from the raster counters
    typedef struct packed {
        logic first;    // first pixel of its tile: sum starts from zero
        logic in_tile;  // pixel lies inside a complete tile
        logic emit;     // bottom-right pixel of a complete tile
    } t_flags;

    // Identity of the tile a result belongs to
    typedef struct packed {
        logic [IDX_W-1:0] tile_row;
        logic [IDX_W-1:0] tile_col;
        logic             last;
    } t_tag;

endpackage

### rtl/core/tile_mean_color.sv
// Top level: tile mean colour of a square RGBA image streamed in raster order.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------------------
//  pixel   | in        | i_valid / o_stall | i_red, i_green, i_blue, i_alpha
//  tile    | out       | o_valid / i_stall | o_tile_row, o_tile_col, o_mean_*, o_last_tile
//
//  One pixel request is taken every cycle while o_stall is low; the rate is set by
//  the read-modify-write of the tile column sum memory, forwarded from the last write.
//  A tile result passes the sum stage, both mean stage registers and the output register.
//  Synchronous active-low reset clears the counters and stage valids; the sum
//  memory needs no clearing, as every tile's first pixel starts its sum at zero.
//  o_stall rises only while a result is held at the output and the mean pipeline
//  behind it is full.
module tile_mean_color import tmc_pkg::*; #(
    parameter int TILE_SIZE  = 40,
    parameter int IMAGE_SIZE = 400
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    input  logic [PIX_W-1:0] i_alpha,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [IDX_W-1:0] o_tile_row,
    output logic [IDX_W-1:0] o_tile_col,
    output logic [PIX_W-1:0] o_mean_red,
    output logic [PIX_W-1:0] o_mean_green,
    output logic [PIX_W-1:0] o_mean_blue,
    output logic [PIX_W-1:0] o_mean_alpha,
    output logic             o_last_tile
);

    localparam int TILES = IMAGE_SIZE / TILE_SIZE;
    localparam int MEM_D = (TILES > 0) ? TILES : 1;
    localparam int AW    = (TILES > 1) ? $clog2(TILES) : 1;

    logic          accept, acc_ready;
    t_chan         pix;
    logic [AW-1:0] addr;
    t_flags        flags;
    t_tag          tag;

    logic  res_valid, res_ready;
    t_sums res_sums;
    t_tag  res_tag;

    logic  mean_valid, out_ready;
    t_chan means;
    t_tag  mean_tag;

    logic  r_out_v;
    t_chan r_out_means;
    t_tag  r_out_tag;

    // a request enters whenever the sum stage is empty or moving on
    assign accept  = i_valid && acc_ready;
    assign o_stall = !acc_ready;
    assign pix     = {i_alpha, i_blue, i_green, i_red};

    tmc_raster #(
        .TILE_SIZE  (TILE_SIZE),
        .IMAGE_SIZE (IMAGE_SIZE),
        .AW         (AW)
    ) u_raster (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .o_addr   (addr),
        .o_flags  (flags),
        .o_tag    (tag)
    );

    // sums live in memory, one entry per tile column of the current tile row
    tmc_accum #(
        .MEM_D (MEM_D),
        .AW    (AW)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pix       (pix),
        .i_addr      (addr),
        .i_flags     (flags),
        .i_tag       (tag),
        .o_ready     (acc_ready),
        .o_res_valid (res_valid),
        .o_sums      (res_sums),
        .o_tag       (res_tag),
        .i_res_ready (res_ready)
    );

    // (sum + area/2) / area per channel, two stages
    tmc_mean #(
        .TILE_SIZE (TILE_SIZE)
    ) u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_sums  (res_sums),
        .i_tag   (res_tag),
        .o_ready (res_ready),
        .o_valid (mean_valid),
        .o_means (means),
        .o_tag   (mean_tag),
        .i_ready (out_ready)
    );

    // output register: holds a result while the consumer stalls
    assign out_ready = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (out_ready && mean_valid) begin
            r_out_means <= means;
            r_out_tag   <= mean_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ready) begin
            r_out_v <= mean_valid;
        end
    end

    assign o_valid      = r_out_v;
    assign o_tile_row   = r_out_tag.tile_row;
    assign o_tile_col   = r_out_tag.tile_col;
    assign o_mean_red   = r_out_means[0];
    assign o_mean_green = r_out_means[1];
    assign o_mean_blue  = r_out_means[2];
    assign o_mean_alpha = r_out_means[3];
    assign o_last_tile  = r_out_tag.last;

endmodule

### rtl/core/tmc_raster.sv
// Raster position counters: tile column address, position flags and tile tag.
module tmc_raster import tmc_pkg::*; #(
    parameter int TILE_SIZE  = 40,
    parameter int IMAGE_SIZE = 400,
    parameter int AW         = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    output logic [AW-1:0] o_addr,
    output t_flags        o_flags,
    output t_tag          o_tag
);

    localparam int TILES = IMAGE_SIZE / TILE_SIZE;
    localparam int CW    = (IMAGE_SIZE > 1) ? $clog2(IMAGE_SIZE) : 1;
    localparam int TW    = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
    localparam int TCW   = (TILES > 0) ? $clog2(TILES + 1) : 1;

    logic [CW-1:0]  r_col, n_col, r_row, n_row;
    logic [TW-1:0]  r_pcol, n_pcol, r_prow, n_prow;
    logic [TCW-1:0] r_tcol, n_tcol, r_trow, n_trow;
    logic           col_end, row_end, pcol_end, prow_end, in_tile;

    assign col_end  = (r_col == CW'(IMAGE_SIZE - 1));
    assign row_end  = (r_row == CW'(IMAGE_SIZE - 1));
    assign pcol_end = (r_pcol == TW'(TILE_SIZE - 1));
    assign prow_end = (r_prow == TW'(TILE_SIZE - 1));

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_pcol = r_pcol;
        n_prow = r_prow;
        n_tcol = r_tcol;
        n_trow = r_trow;
        if (i_accept) begin
            if (col_end) begin
                n_col  = '0;
                n_pcol = '0;
                n_tcol = '0;
                if (row_end) begin
                    n_row  = '0;
                    n_prow = '0;
                    n_trow = '0;
                end else begin
                    n_row = r_row + CW'(1);
                    if (prow_end) begin
                        n_prow = '0;
                        n_trow = r_trow + TCW'(1);
                    end else begin
                        n_prow = r_prow + TW'(1);
                    end
                end
            end else begin
                n_col = r_col + CW'(1);
                if (pcol_end) begin
                    n_pcol = '0;
                    n_tcol = r_tcol + TCW'(1);
                end else begin
                    n_pcol = r_pcol + TW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pcol <= '0;
            r_prow <= '0;
            r_tcol <= '0;
            r_trow <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pcol <= n_pcol;
            r_prow <= n_prow;
            r_tcol <= n_tcol;
            r_trow <= n_trow;
        end
    end

    // pixels right of or below the last complete tile are ignored
    assign in_tile = (r_tcol < TCW'(TILES)) && (r_trow < TCW'(TILES));

    assign o_addr          = AW'(r_tcol);
    assign o_flags.first   = (r_pcol == '0) && (r_prow == '0);
    assign o_flags.in_tile = in_tile;
    assign o_flags.emit    = in_tile && pcol_end && prow_end;
    assign o_tag.tile_row  = IDX_W'(r_trow);
    assign o_tag.tile_col  = IDX_W'(r_tcol);
    assign o_tag.last      = (r_trow == TCW'(TILES - 1)) && (r_tcol == TCW'(TILES - 1));

endmodule

### rtl/core/tmc_accum.sv
// Tile column sum memory with read-modify-write stage and write forwarding.
module tmc_accum import tmc_pkg::*; #(
    parameter int MEM_D = 10,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  t_chan         i_pix,
    input  logic [AW-1:0] i_addr,
    input  t_flags        i_flags,
    input  t_tag          i_tag,
    output logic          o_ready,
    output logic          o_res_valid,
    output t_sums         o_sums,
    output t_tag          o_tag,
    input  logic          i_res_ready
);

    t_sums         mem [MEM_D];
    t_sums         r_rdata;
    logic          r_s1_v;
    t_chan         r_pix;
    logic [AW-1:0] r_addr;
    t_flags        r_flags;
    t_tag          r_tag;
    logic          r_last_v;
    logic [AW-1:0] r_last_addr;
    t_sums         r_last_sums;

    t_sums base, sum_new;
    logic  s1_adv, wr;

    assign s1_adv  = r_s1_v && (!r_flags.emit || i_res_ready);
    assign o_ready = !r_s1_v || s1_adv;
    assign wr      = s1_adv && r_flags.in_tile;

    // newest value: zero on a tile's first pixel, else last write if it hit
    // this entry (it may have landed on the same edge as the read)
    always_comb begin
        if (r_flags.first) begin
            base = '0;
        end else if (r_last_v && (r_last_addr == r_addr)) begin
            base = r_last_sums;
        end else begin
            base = r_rdata;
        end
        for (int k = 0; k < CH; k++) begin
            sum_new[k] = base[k] + SUM_W'(r_pix[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem[r_addr] <= sum_new;
        end
        if (i_accept) begin
            r_rdata <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pix   <= i_pix;
            r_addr  <= i_addr;
            r_flags <= i_flags;
            r_tag   <= i_tag;
        end
        if (wr) begin
            r_last_addr <= r_addr;
            r_last_sums <= sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_last_v <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_v <= i_accept;
            end
            if (wr) begin
                r_last_v <= 1'b1;
            end
        end
    end

    assign o_res_valid = r_s1_v && r_flags.emit;
    assign o_sums      = sum_new;
    assign o_tag       = r_tag;

endmodule

### rtl/core/tmc_mean.sv
// Rounded mean by constant tile area: reciprocal multiply then one correction.
module tmc_mean import tmc_pkg::*; #(
    parameter int TILE_SIZE = 40
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_sums i_sums,
    input  t_tag  i_tag,
    output logic  o_ready,
    output logic  o_valid,
    output t_chan o_means,
    output t_tag  o_tag,
    input  logic  i_ready
);

    localparam int AREA   = TILE_SIZE * TILE_SIZE;
    localparam int HALF   = AREA / 2;
    localparam int AREA_W = $clog2(AREA + 1);
    localparam int K      = X_W + ((AREA > 1) ? $clog2(AREA) : 0);
    localparam int M_W    = X_W + 1;
    localparam int P_W    = X_W + M_W;
    localparam int R_W    = X_W + AREA_W;
    // floor(2^K / AREA): quotient estimate is exact or one low
    localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << K) / 64'(AREA));

    logic r_s2_v, r_s3_v, s2_ready, s3_ready;
    t_xs  r_s2_x, r_s3_x, r_s3_q;
    t_tag r_s2_tag, r_s3_tag;

    logic [CH-1:0][P_W-1:0] prod;
    t_xs                    q0;
    logic [CH-1:0][R_W-1:0] qa, rem;
    t_xs                    q;

    assign s3_ready = !r_s3_v || i_ready;
    assign s2_ready = !r_s2_v || s3_ready;
    assign o_ready  = s2_ready;

    always_comb begin
        for (int k = 0; k < CH; k++) begin
            prod[k] = P_W'(r_s2_x[k]) * P_W'(RECIP);
            q0[k]   = X_W'(prod[k] >> K);
            qa[k]   = R_W'(r_s3_q[k]) * R_W'(AREA);
            rem[k]  = R_W'(r_s3_x[k]) - qa[k];
            q[k]    = (rem[k] >= R_W'(AREA)) ? r_s3_q[k] + X_W'(1) : r_s3_q[k];
            o_means[k] = q[k][PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            for (int k = 0; k < CH; k++) begin
                r_s2_x[k] <= X_W'(i_sums[k]) + X_W'(HALF);
            end
            r_s2_tag <= i_tag;
        end
        if (s3_ready && r_s2_v) begin
            r_s3_q   <= q0;
            r_s3_x   <= r_s2_x;
            r_s3_tag <= r_s2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_v <= i_valid;
            end
            if (s3_ready) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    assign o_valid = r_s3_v;
    assign o_tag   = r_s3_tag;

endmodule

### rtl/core/tmc_checker.sv
// Port-level checks for the tile mean colour block, bound to the top level.
module tmc_checker import tmc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [IDX_W-1:0] o_tile_row,
    input logic [IDX_W-1:0] o_tile_col,
    input logic [PIX_W-1:0] o_mean_red,
    input logic [PIX_W-1:0] o_mean_green,
    input logic [PIX_W-1:0] o_mean_blue,
    input logic [PIX_W-1:0] o_mean_alpha,
    input logic             o_last_tile
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tile_row) && $stable(o_tile_col)
            && $stable(o_mean_red) && $stable(o_mean_green) && $stable(o_mean_blue)
            && $stable(o_mean_alpha) && $stable(o_last_tile))
        else $error("result changed while stalled");

    // back-pressure only arises from a result held at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // the final tile sits on the diagonal of a square image
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_tile |-> o_tile_row == o_tile_col)
        else $error("last tile off the diagonal");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind tile_mean_color tmc_checker u_tmc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_tile_row   (o_tile_row),
    .o_tile_col   (o_tile_col),
    .o_mean_red   (o_mean_red),
    .o_mean_green (o_mean_green),
    .o_mean_blue  (o_mean_blue),
    .o_mean_alpha (o_mean_alpha),
    .o_last_tile  (o_last_tile)
);

### bench/tile_mean_color_tb.sv
// Self-checking testbench for tile_mean_color: streams RGBA pixels, predicts tile means.
module tile_mean_color_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmc_pkg::*;

    // Geometry under test: the block's own defaults, a 400 x 400 image in 40 x 40 tiles
    localparam int TILE_SIZE  = 40;
    localparam int IMAGE_SIZE = 400;
    localparam int TILES      = IMAGE_SIZE / TILE_SIZE;
    localparam int unsigned TILE_AREA = TILE_SIZE * TILE_SIZE;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 16;   // lets a last result pass the sum, mean and output registers
    localparam int HOLD_CYCLES   = 600;  // long receiver hold-off, fills the mean pipeline
    localparam int MAX_GAP       = 8;

    // One full image, one tile row of the next image and the directed pixels
    localparam int unsigned TOTAL_PIXELS =
        IMAGE_SIZE * IMAGE_SIZE + IMAGE_SIZE * TILE_SIZE + 64;
    localparam int unsigned LIMIT_CYCLES =
        3 * (TOTAL_PIXELS * (MAX_GAP + 2) + 200 * HOLD_CYCLES);

    // Channel positions inside a t_chan
    localparam int RED   = 0;
    localparam int GREEN = 1;
    localparam int BLUE  = 2;
    localparam int ALPHA = 3;

    // Content of one tile; flat and split tiles give exact and half-way means
    typedef enum int {
        STYLE_RANDOM,
        STYLE_MAX,
        STYLE_ZERO,
        STYLE_FLAT,
        STYLE_SPLIT
    } t_tile_style;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct packed {
        t_tag  tag;
        t_chan mean;
    } t_tile_result;

    // Block ports
    logic             i_clk    = 1'b0;
    logic             i_rst_n  = 1'b0;
    logic             i_valid  = 1'b0;
    logic             o_stall;
    logic [PIX_W-1:0] i_red    = '0;
    logic [PIX_W-1:0] i_green  = '0;
    logic [PIX_W-1:0] i_blue   = '0;
    logic [PIX_W-1:0] i_alpha  = '0;
    logic             o_valid;
    logic             i_stall  = 1'b0;
    logic [IDX_W-1:0] o_tile_row;
    logic [IDX_W-1:0] o_tile_col;
    logic [PIX_W-1:0] o_mean_red;
    logic [PIX_W-1:0] o_mean_green;
    logic [PIX_W-1:0] o_mean_blue;
    logic [PIX_W-1:0] o_mean_alpha;
    logic             o_last_tile;

    // Predictor state: per tile column sums and the raster position of the next pixel
    t_sums       column_sums [TILES];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    t_tile_result tile_expect_q [$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count    = 0;

    // Sender burst state and the hold-off request handed to the receiver process
    int unsigned burst_left   = 0;
    bit          steady_input = 1'b0;
    int unsigned hold_request = 0;

    // Content plan for the tile columns of the current tile row
    t_tile_style tile_style [TILES];
    t_chan       tile_base  [TILES];
    t_chan       tile_alt   [TILES];

    tile_mean_color #(
        .TILE_SIZE  (TILE_SIZE),
        .IMAGE_SIZE (IMAGE_SIZE)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_alpha      (i_alpha),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tile_row   (o_tile_row),
        .o_tile_col   (o_tile_col),
        .o_mean_red   (o_mean_red),
        .o_mean_green (o_mean_green),
        .o_mean_blue  (o_mean_blue),
        .o_mean_alpha (o_mean_alpha),
        .o_last_tile  (o_last_tile)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic logic [PIX_W-1:0] tile_mean(input logic [SUM_W-1:0] sum);
        return PIX_W'((sum + TILE_AREA / 2) / TILE_AREA);
    endfunction

    // Fold one accepted pixel into the sums; queue a tile result on its bottom-right pixel
    function automatic void accumulate_pixel(input t_chan px);
        int unsigned  tcol;
        int unsigned  trow;
        t_tile_result res;
        tcol = col_pos / TILE_SIZE;
        trow = row_pos / TILE_SIZE;
        // first pixel of a tile row starts every column sum afresh
        if (col_pos == 0 && row_pos % TILE_SIZE == 0) begin
            foreach (column_sums[i]) column_sums[i] = '0;
        end
        if (tcol < TILES && trow < TILES) begin
            for (int c = 0; c < CH; c++) begin
                column_sums[tcol][c] = column_sums[tcol][c] + SUM_W'(px[c]);
            end
            if (col_pos % TILE_SIZE == TILE_SIZE - 1 &&
                row_pos % TILE_SIZE == TILE_SIZE - 1) begin
                res.tag.tile_row = IDX_W'(trow);
                res.tag.tile_col = IDX_W'(tcol);
                res.tag.last     = (trow == TILES - 1 && tcol == TILES - 1);
                for (int c = 0; c < CH; c++) begin
                    res.mean[c] = tile_mean(column_sums[tcol][c]);
                end
                tile_expect_q.insert(tile_expect_q.size(), res);
            end
        end
        // raster advance, wrapping to a fresh image after the last pixel
        col_pos++;
        if (col_pos >= IMAGE_SIZE) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= IMAGE_SIZE) row_pos = 0;
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : tile_checker
        t_tile_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tile_expect_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: tile result with none expected: expected none, got row %0d col %0d",
                         $time, o_tile_row, o_tile_col);
            end else begin
                want = tile_expect_q.pop_front();
                check_field("tile_row",   32'(want.tag.tile_row), 32'(o_tile_row));
                check_field("tile_col",   32'(want.tag.tile_col), 32'(o_tile_col));
                check_field("mean_red",   32'(want.mean[RED]),    32'(o_mean_red));
                check_field("mean_green", 32'(want.mean[GREEN]),  32'(o_mean_green));
                check_field("mean_blue",  32'(want.mean[BLUE]),   32'(o_mean_blue));
                check_field("mean_alpha", 32'(want.mean[ALPHA]),  32'(o_mean_alpha));
                check_field("last_tile",  32'(want.tag.last),     32'(o_last_tile));
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Stall pattern changes after each random span; a hold-off request overrides it
    initial begin : stall_pattern
        t_stall_mode mode;
        int unsigned span;
        int unsigned period;
        int unsigned hold_left;
        int unsigned phase;
        hold_left = 0;
        phase     = 0;
        forever begin
            mode   = t_stall_mode'($urandom_range(STALL_NONE, STALL_PERIODIC));
            span   = $urandom_range(20, 400);
            period = $urandom_range(2, 7);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_request > 0) begin
                    hold_left    = hold_request;
                    hold_request = 0;
                end
                phase++;
                if (hold_left > 0) begin
                    hold_left--;
                    i_stall <= 1'b1;
                end else begin
                    case (mode)
                        STALL_NONE:  i_stall <= 1'b0;
                        STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                        STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                        default:     i_stall <= (phase % period == 0);
                    endcase
                end
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // Offer one pixel request, hold it until taken, then predict its effect
    task automatic send_pixel(input t_chan px);
        int unsigned gap;
        if (!steady_input && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(3, MAX_GAP)
                                                : $urandom_range(1, 2);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 1500)
                                                      : $urandom_range(1, 40);
        end
        if (burst_left > 0) burst_left--;
        i_valid <= 1'b1;
        i_red   <= px[RED];
        i_green <= px[GREEN];
        i_blue  <= px[BLUE];
        i_alpha <= px[ALPHA];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        accumulate_pixel(px);
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        while (tile_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // Pick a content style per tile column; split tiles mix two values on a checkerboard
    function automatic void choose_tile_styles(input bit uniform_only);
        for (int t = 0; t < TILES; t++) begin
            if (!uniform_only && $urandom_range(0, 1) == 0) tile_style[t] = STYLE_RANDOM;
            else tile_style[t] = t_tile_style'($urandom_range(STYLE_MAX, STYLE_SPLIT));
            for (int c = 0; c < CH; c++) begin
                if ($urandom_range(0, 3) == 0) begin
                    tile_base[t][c] = '0;
                    tile_alt[t][c]  = '1;
                end else begin
                    tile_base[t][c] = PIX_W'($urandom_range(0, 254));
                    tile_alt[t][c]  = tile_base[t][c] + PIX_W'(1);
                end
            end
        end
    endfunction

    function automatic t_chan next_pixel();
        int unsigned tcol;
        t_chan       px;
        tcol = col_pos / TILE_SIZE;
        px   = $urandom;
        if (tcol < TILES) begin
            case (tile_style[tcol])
                STYLE_MAX:   px = '1;
                STYLE_ZERO:  px = '0;
                STYLE_FLAT:  px = tile_base[tcol];
                STYLE_SPLIT: px = ((col_pos + row_pos) % 2 == 1) ? tile_alt[tcol]
                                                                : tile_base[tcol];
                default: ;
            endcase
        end
        return px;
    endfunction

    // Send pixels up to the next tile row boundary; squeeze holds the receiver off and
    // drops the input gaps over the last pixel row, where the results come out
    task automatic send_tile_row(input bit squeeze);
        do begin
            if (squeeze && row_pos % TILE_SIZE == TILE_SIZE - 1 && col_pos == 0) begin
                steady_input = 1'b1;
                hold_request = HOLD_CYCLES;
            end
            send_pixel(next_pixel());
        end while (!(col_pos == 0 && row_pos % TILE_SIZE == 0));
        steady_input = 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // Opening pixels of the image: clearing on the very first pixel, channel extremes,
    // and every bit of every channel at both values
    task automatic test_channel_extremes();
        t_chan            px;
        logic [PIX_W-1:0] one_bit;
        send_pixel('0);
        send_pixel('1);
        send_pixel({CH{8'h55}});
        send_pixel({CH{8'hAA}});
        for (int c = 0; c < CH; c++) begin
            px    = '0;
            px[c] = '1;
            send_pixel(px);
        end
        for (int b = 0; b < PIX_W; b++) begin
            one_bit    = '0;
            one_bit[b] = 1'b1;
            px = {CH{one_bit}};
            send_pixel(px);
            send_pixel(~px);
        end
    endtask

    // First tile row under back-pressure, then a full drain with the sender paused
    task automatic test_squeezed_tile_row();
        choose_tile_styles(1'b0);
        send_tile_row(1'b1);
        pause_until_drained();
    endtask

    // Tiles of all-max, all-zero, flat and half-way content: exact means and rounding
    task automatic test_uniform_tiles();
        repeat (2) begin
            choose_tile_styles(1'b1);
            send_tile_row(1'b0);
        end
    endtask

    // Remaining tile rows up to the image wrap, which carries the last tile flag
    task automatic test_random_tiles();
        do begin
            choose_tile_styles($urandom_range(0, 3) == 0);
            send_tile_row(1'b0);
            if ($urandom_range(0, 2) == 0) pause_until_drained();
        end while (!(row_pos == 0 && col_pos == 0));
    endtask

    // Top tile row of the following image: sums must not carry over the wrap
    task automatic test_next_image();
        choose_tile_styles(1'b0);
        send_tile_row(1'b0);
    endtask

    // ---------------------------------------------------------------- run control

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : test_sequence
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_channel_extremes();
        test_squeezed_tile_row();
        test_uniform_tiles();
        test_random_tiles();
        test_next_image();

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### tile_mean_color.f
rtl/core/tmc_pkg.sv
rtl/core/tmc_raster.sv
rtl/core/tmc_accum.sv
rtl/core/tmc_mean.sv
rtl/core/tile_mean_color.sv
rtl/core/tmc_checker.sv
bench/tile_mean_color_tb.sv
